/* hdl/bitset_frame_reader_top_assert.svh */
// Assertion macros for the bitset frame reader.
// Depends on signals named clk and rst_n in the scope that uses them.
`ifndef BITSET_FRAME_READER_TOP_ASSERT_SVH
`define BITSET_FRAME_READER_TOP_ASSERT_SVH

// Checked at every rising edge once reset is released.
`define BFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset cycles included.
`define BFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/bfr_pkg.sv */
// Shared types and constants for the bitset frame reader.
// No dependencies; the interfaces, core, top level and checker use it.
`timescale 1ns / 1ps

package bfr_pkg;

  // Default capacity in bits and words per checksum group.
  localparam int unsigned MAX_BITS_DEF    = 4096;
  localparam int unsigned GROUP_WORDS_DEF = 8;

  // Fixed widths of the result fields.
  localparam int unsigned WORD_INDEX_W = 7;
  localparam int unsigned BIT_COUNT_W  = 13;

  // Framing bytes.
  localparam logic [7:0] HEADER_BYTE = 8'h00;
  localparam logic [7:0] TERM_BYTE   = 8'hFF;

  // Status codes reported with every result beat.
  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_DONE       = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_BAD_CHECK  = 3'd4,
    ST_BAD_TERM   = 3'd5
  } status_t;

  // One result beat.
  typedef struct packed {
    logic                    word_valid;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [31:0]             word_data;
    logic [BIT_COUNT_W-1:0]  bit_count;
    status_t                 status;
  } res_t;

endpackage

/* hdl/bfr_ifs.sv */
// Valid/ready channel interfaces for the bitset frame reader.
// Depends on bfr_pkg for field widths.
`timescale 1ns / 1ps

// Input byte channel.
interface bfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel.
interface bfr_out_if;
  logic                              valid;
  logic                              ready;
  logic                              word_valid;
  logic [bfr_pkg::WORD_INDEX_W-1:0]  word_index;
  logic [31:0]                       word_data;
  logic [bfr_pkg::BIT_COUNT_W-1:0]   bit_count;
  logic [2:0]                        status;

  modport source (output valid, output word_valid, output word_index, output word_data,
                  output bit_count, output status, input ready);
  modport sink   (input valid, input word_valid, input word_index, input word_data,
                  input bit_count, input status, output ready);
endinterface

/* hdl/bfr_core.sv */
// Frame parser state machine: one byte per step, one result per byte.
// Depends on bfr_pkg for the status codes and the result struct.
`timescale 1ns / 1ps

module bfr_core #(
  parameter int unsigned MAX_BITS    = bfr_pkg::MAX_BITS_DEF,
  parameter int unsigned GROUP_WORDS = bfr_pkg::GROUP_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    in_byte,
  output bfr_pkg::res_t res
);

  localparam int unsigned BT_W      = $clog2(MAX_BITS + 1);
  localparam int unsigned WORDS_MAX = (MAX_BITS + 31) / 32;
  localparam int unsigned NW_W      = $clog2(WORDS_MAX + 1);
  localparam int unsigned GC_W      = (GROUP_WORDS > 1) ? $clog2(GROUP_WORDS) : 1;
  localparam logic [GC_W-1:0] GC_LAST  = GC_W'(GROUP_WORDS - 1);
  localparam logic [1:0]      LAST_POS = 2'd3;
  localparam logic [31:0]     MAX_CNT  = 32'(MAX_BITS);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_DATA,
    PH_CHECK,
    PH_TERM
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [31:0]       sh_r, sh_nxt;
  logic [BT_W-1:0]   bt_r, bt_nxt;
  logic [NW_W-1:0]   wt_r, wt_nxt;
  logic [NW_W-1:0]   nw_r, nw_nxt;
  logic [GC_W-1:0]   gc_r, gc_nxt;
  logic [7:0]        gx_r, gx_nxt;

  logic [31:0]       shifted;
  logic [32:0]       word_sum;
  logic [NW_W-1:0]   nw_inc;
  logic              size_bad;

  assign shifted  = {in_byte, sh_r[31:8]};
  assign word_sum = {1'b0, shifted} + 33'd31;
  assign nw_inc   = nw_r + NW_W'(1);
  assign size_bad = (shifted == 32'd0) || shifted[31] || (shifted > MAX_CNT);

  // Next state and the result beat for the byte at the input.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sh_nxt    = sh_r;
    bt_nxt    = bt_r;
    wt_nxt    = wt_r;
    nw_nxt    = nw_r;
    gc_nxt    = gc_r;
    gx_nxt    = gx_r;
    res       = '0;
    res.status = bfr_pkg::ST_BUSY;

    unique case (phase_r)
      PH_HEADER: begin
        bt_nxt  = '0;
        wt_nxt  = '0;
        nw_nxt  = '0;
        gc_nxt  = '0;
        gx_nxt  = '0;
        pos_nxt = '0;
        sh_nxt  = '0;
        if (in_byte == bfr_pkg::HEADER_BYTE) begin
          phase_nxt = PH_SIZE;
        end else begin
          res.status = bfr_pkg::ST_BAD_HEADER;
        end
      end
      PH_SIZE: begin
        sh_nxt = shifted;
        if (pos_r == LAST_POS) begin
          pos_nxt = '0;
          sh_nxt  = '0;
          if (size_bad) begin
            res.status = bfr_pkg::ST_BAD_SIZE;
            phase_nxt  = PH_HEADER;
          end else begin
            bt_nxt    = BT_W'(shifted);
            wt_nxt    = NW_W'(word_sum[32:5]);
            nw_nxt    = '0;
            gc_nxt    = '0;
            gx_nxt    = '0;
            phase_nxt = PH_DATA;
          end
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
      PH_DATA: begin
        sh_nxt = shifted;
        gx_nxt = gx_r ^ in_byte;
        if (pos_r == LAST_POS) begin
          res.word_valid = 1'b1;
          res.word_index = bfr_pkg::WORD_INDEX_W'(32'(nw_r));
          res.word_data  = shifted;
          pos_nxt = '0;
          sh_nxt  = '0;
          nw_nxt  = nw_inc;
          // A full group is followed by its checksum byte.
          if (gc_r == GC_LAST) begin
            gc_nxt    = '0;
            phase_nxt = PH_CHECK;
          end else begin
            gc_nxt = gc_r + GC_W'(1);
            if (nw_inc >= wt_r) begin
              phase_nxt = PH_TERM;
            end
          end
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
      PH_CHECK: begin
        if (in_byte != gx_r) begin
          res.status = bfr_pkg::ST_BAD_CHECK;
          phase_nxt  = PH_HEADER;
        end else begin
          gx_nxt    = '0;
          phase_nxt = (nw_r >= wt_r) ? PH_TERM : PH_DATA;
        end
      end
      default: begin
        res.status = (in_byte == bfr_pkg::TERM_BYTE) ? bfr_pkg::ST_DONE
                                                     : bfr_pkg::ST_BAD_TERM;
        phase_nxt  = PH_HEADER;
      end
    endcase

    res.bit_count = bfr_pkg::BIT_COUNT_W'(32'(bt_nxt));
  end

  // Parser state advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      sh_r    <= '0;
      bt_r    <= '0;
      wt_r    <= '0;
      nw_r    <= '0;
      gc_r    <= '0;
      gx_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sh_r    <= sh_nxt;
      bt_r    <= bt_nxt;
      wt_r    <= wt_nxt;
      nw_r    <= nw_nxt;
      gc_r    <= gc_nxt;
      gx_r    <= gx_nxt;
    end
  end

endmodule

/* hdl/bitset_frame_reader_top.sv */
// A result beat is offered in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; the output
// register takes a new beat in the cycle the old one leaves.
// Reset: synchronous, active low; the parser waits for a header, output empty.
// Depends on bfr_pkg, bfr_ifs and bfr_core.
`timescale 1ns / 1ps

module bitset_frame_reader_top #(
  parameter int unsigned MAX_BITS    = bfr_pkg::MAX_BITS_DEF,
  parameter int unsigned GROUP_WORDS = bfr_pkg::GROUP_WORDS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  bfr_in_if.sink    in_bus,
  bfr_out_if.source out_bus
);

  bfr_pkg::res_t core_res;
  bfr_pkg::res_t res_r;
  logic          out_valid_r;
  logic          in_ready;
  logic          step;

  // A byte is taken whenever the output register is empty or draining.
  assign in_ready     = !out_valid_r || out_bus.ready;
  assign step         = in_bus.valid && in_ready;
  assign in_bus.ready = in_ready;

  bfr_core #(
    .MAX_BITS    (MAX_BITS),
    .GROUP_WORDS (GROUP_WORDS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_byte (in_bus.in_byte),
    .res     (core_res)
  );

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= core_res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.word_valid = res_r.word_valid;
  assign out_bus.word_index = res_r.word_index;
  assign out_bus.word_data  = res_r.word_data;
  assign out_bus.bit_count  = res_r.bit_count;
  assign out_bus.status     = res_r.status;

endmodule

/* hdl/bfr_checker.sv */
// Port-level checks for the bitset frame reader, bound to the top level.
// Depends on bfr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bitset_frame_reader_top_assert.svh"

module bfr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_word_valid,
  input logic [bfr_pkg::WORD_INDEX_W-1:0] out_word_index,
  input logic [31:0]                      out_word_data,
  input logic [bfr_pkg::BIT_COUNT_W-1:0]  out_bit_count,
  input logic [2:0]                       out_status
);

  // A stalled result beat stays offered with the same word.
  `BFR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word_data), "result beat dropped or changed while stalled")

  // The output side is empty in the cycle after reset.
  `BFR_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_valid, "result offered right after reset")

  // A word only completes while the frame is still in progress.
  `BFR_ASSERT(a_word_busy, out_valid && out_word_valid |-> out_status == bfr_pkg::ST_BUSY, "word emitted with a final status")

  // Without a word the index and data read as zero.
  `BFR_ASSERT(a_word_zero, out_valid && !out_word_valid |-> out_word_index == '0 && out_word_data == '0, "stale word fields")

  // Header and size errors come before any count is accepted.
  `BFR_ASSERT(a_err_count, out_valid && (out_status == bfr_pkg::ST_BAD_HEADER || out_status == bfr_pkg::ST_BAD_SIZE) |-> out_bit_count == '0, "bit count shown on an early error")

endmodule

bind bitset_frame_reader_top bfr_checker u_bfr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_word_valid (out_bus.word_valid),
  .out_word_index (out_bus.word_index),
  .out_word_data  (out_bus.word_data),
  .out_bit_count  (out_bus.bit_count),
  .out_status     (out_bus.status)
);
